### rtl/core/tpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpd_pkg;

	localparam int MAX_BINS   = 16384;
	localparam int AMP_BITS   = 16;
	localparam int BIN_W      = 14;
	localparam int BC_W       = 15;
	localparam int THR_W      = 16;
	localparam int HZ_W       = 24;
	localparam int FREQ_W     = 26;
	localparam int M1_W       = 44;
	localparam int M2_W       = 58;
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_BIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HZ_PER_BIN = 3'd5;

	typedef struct packed {
		logic [BC_W-1:0]  bin_count;
		logic [BIN_W-1:0] low_bin;
		logic [BIN_W-1:0] peak_start_bin;
		logic [BIN_W-1:0] high_bin;
		logic [THR_W-1:0] threshold_q16;
		logic [HZ_W-1:0]  hz_per_bin_q16;
	} cfg_t;

	// one finished frame, front to back
	typedef struct packed {
		logic [M1_W-1:0]  m1;
		logic [M2_W-1:0]  m2;
		logic             has_peak;
		logic [BIN_W-1:0] pbin;
	} frame_t;

endpackage

`default_nettype wire

### rtl/core/tpd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tpd_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire tpd_pkg::cfg_t              cfg,
	input  wire logic                       bin_valid,
	output logic                            bin_stall,
	input  wire logic [15:0]                amplitude,
	input  wire logic                       last,
	input  wire logic [tpd_pkg::QCNT_W-1:0] queue_count,
	output logic                            push,
	output tpd_pkg::frame_t                 push_frame
);
	import tpd_pkg::*;

	logic                bin_accept;
	logic [BIN_W-1:0]    bin_idx_q;
	logic [AMP_BITS-1:0] amp_in;

	logic                v_s1, last_s1, mom_s1, pk_s1;
	logic [AMP_BITS-1:0] a_s1;
	logic [BIN_W-1:0]    q_s1;

	logic                v_s2, last_s2, has_s2;
	logic [29:0]         p1_s2;
	logic [BIN_W-1:0]    q_s2, pbin_s2;

	logic                v_s3, last_s3, has_s3;
	logic [29:0]         p1_s3;
	logic [M1_W-1:0]     p2_s3;
	logic [BIN_W-1:0]    pbin_s3;

	logic [AMP_BITS-1:0] pk_val_q;
	logic [BIN_W-1:0]    pk_idx_q;
	logic [AMP_BITS-1:0] pk_val_cur;
	logic [BIN_W-1:0]    pk_idx_cur;

	logic [M1_W-1:0]     m1_q, m1_next;
	logic [M2_W-1:0]     m2_q, m2_next;
	logic [QCNT_W:0]     lasts_in_flight;
	logic [QCNT_W:0]     committed;

	assign amp_in = amplitude[AMP_BITS-1:0];

	// reserve a queue slot for every frame end still in the pipe
	assign lasts_in_flight = (QCNT_W+1)'(v_s1 & last_s1) + (QCNT_W+1)'(v_s2 & last_s2)
		+ (QCNT_W+1)'(v_s3 & last_s3);
	assign committed  = {1'b0, queue_count} + lasts_in_flight;
	assign bin_stall  = committed >= (QCNT_W+1)'(QUEUE_DEPTH);
	assign bin_accept = bin_valid & ~bin_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_idx_q <= '0;
		end else if (bin_accept) begin
			if (last || bin_idx_q == BIN_W'(MAX_BINS - 1))
				bin_idx_q <= '0;
			else
				bin_idx_q <= bin_idx_q + 1'b1;
		end
	end

	// stage 1: classify
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= bin_accept;
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= amp_in;
		q_s1    <= bin_idx_q;
		last_s1 <= last;
		mom_s1  <= (bin_idx_q >= cfg.low_bin) && (bin_idx_q <= cfg.high_bin);
		pk_s1   <= (bin_idx_q >= cfg.peak_start_bin) && (bin_idx_q < cfg.high_bin);
	end

	// peak tracking on stage 1
	always_comb begin
		pk_val_cur = pk_val_q;
		pk_idx_cur = pk_idx_q;
		if (pk_s1 && a_s1 > pk_val_q) begin
			pk_val_cur = a_s1;
			pk_idx_cur = q_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_val_q <= '0;
			pk_idx_q <= '0;
		end else if (v_s1) begin
			if (last_s1) begin
				pk_val_q <= '0;
				pk_idx_q <= '0;
			end else begin
				pk_val_q <= pk_val_cur;
				pk_idx_q <= pk_idx_cur;
			end
		end
	end

	// stage 2: a*q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		p1_s2   <= mom_s1 ? ({14'b0, a_s1} * {16'b0, q_s1}) : '0;
		q_s2    <= q_s1;
		last_s2 <= last_s1;
		has_s2  <= pk_val_cur != '0;
		pbin_s2 <= (pk_val_cur != '0) ? pk_idx_cur : '0;
	end

	// stage 3: a*q*q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		p1_s3   <= p1_s2;
		p2_s3   <= {14'b0, p1_s2} * {30'b0, q_s2};
		last_s3 <= last_s2;
		has_s3  <= has_s2;
		pbin_s3 <= pbin_s2;
	end

	// accumulate
	assign m1_next = m1_q + {14'b0, p1_s3};
	assign m2_next = m2_q + {14'b0, p2_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m1_q <= '0;
			m2_q <= '0;
		end else if (v_s3) begin
			if (last_s3) begin
				m1_q <= '0;
				m2_q <= '0;
			end else begin
				m1_q <= m1_next;
				m2_q <= m2_next;
			end
		end
	end

	assign push                = v_s3 & last_s3;
	assign push_frame.m1       = m1_next;
	assign push_frame.m2       = m2_next;
	assign push_frame.has_peak = has_s3;
	assign push_frame.pbin     = pbin_s3;

endmodule

`default_nettype wire

### rtl/core/tpd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tpd_queue (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire tpd_pkg::frame_t            push_frame,
	input  wire logic                       pop,
	output tpd_pkg::frame_t                 head,
	output logic                            empty,
	output logic [tpd_pkg::QCNT_W-1:0]      count
);
	import tpd_pkg::*;

	frame_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = count_q == '0;
	assign count = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < QCNT_W'(QUEUE_DEPTH)) || pop)
		else $error("frame queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("frame queue underflow");

endmodule

`default_nettype wire

### rtl/core/tpd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tpd_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tpd_pkg::cfg_t                 cfg,
	input  wire tpd_pkg::frame_t               head,
	input  wire logic                          empty,
	output logic                               pop,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic                               treble_found,
	output logic [tpd_pkg::BIN_W-1:0]          peak_bin,
	output logic [tpd_pkg::FREQ_W-1:0]         frequency_q8
);
	import tpd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL0 = 3'd1;
	localparam logic [2:0] ST_MUL1 = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_CMP  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]        state_q;
	frame_t            rec_q;
	logic [30:0]       tb_q;
	logic [52:0]       plo_q, phi_q;
	logic [37:0]       fprod_q;
	logic [74:0]       rhs_q;
	logic              found_q;
	logic [BIN_W-1:0]  pbin_q;
	logic [FREQ_W-1:0] freq_q;

	logic [74:0]       lhs;
	logic              found_now;
	logic [38:0]       fround;
	logic [30:0]       fshift;

	assign pop = (state_q == ST_IDLE) && !empty;

	// m2*65536 > m1*threshold*bin_count
	assign lhs       = {1'b0, rec_q.m2, 16'b0};
	assign found_now = ({1'b0, cfg.high_bin} < cfg.bin_count) && (rec_q.m1 != '0)
		&& (lhs > rhs_q);
	assign fround    = {1'b0, fprod_q} + 39'd128;
	assign fshift    = fround[38:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (!empty) state_q <= ST_MUL0;
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_CMP;
				ST_CMP:  state_q <= ST_OUT;
				ST_OUT:  if (!result_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!empty)
					rec_q <= head;
			end
			ST_MUL0: begin
				tb_q <= {15'b0, cfg.threshold_q16} * {16'b0, cfg.bin_count};
			end
			ST_MUL1: begin
				plo_q   <= {31'b0, rec_q.m1[21:0]} * {22'b0, tb_q};
				phi_q   <= {31'b0, rec_q.m1[43:22]} * {22'b0, tb_q};
				fprod_q <= {24'b0, rec_q.pbin} * {14'b0, cfg.hz_per_bin_q16};
			end
			ST_SUM: begin
				rhs_q <= {phi_q, 22'b0} + {22'b0, plo_q};
			end
			ST_CMP: begin
				found_q <= found_now;
				pbin_q  <= rec_q.pbin;
				if (!found_now || !rec_q.has_peak)
					freq_q <= '0;
				else if (fshift[30:FREQ_W] != '0)
					freq_q <= '1;
				else
					freq_q <= fshift[FREQ_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign result_valid = state_q == ST_OUT;
	assign treble_found = found_q;
	assign peak_bin     = pbin_q;
	assign frequency_q8 = freq_q;

	a_freq_needs_found: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && frequency_q8 != '0) |-> treble_found)
		else $error("frequency given without treble");

endmodule

`default_nettype wire

### rtl/core/treble_peak_detector_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Treble peak detector. Spectrum bins stream in one per request, in bin order,
// and the front end takes one bin every cycle while bin_stall is low: a
// three-stage multiply pipe forms a*q and a*q*q and accumulates both moments
// while the peak of the search range is tracked. The request flagged last
// closes the frame; its sums and peak go into a four-frame queue, and the
// evaluator pulls frames from it one at a time and gives one result per frame
// after a threshold product, a split 44x31 moment product, a wide add and a
// compare, held until the result request is taken. bin_stall rises only when
// the queue plus the frame ends still in the pipe would fill it. Configuration
// writes are meant for idle periods only.
module treble_peak_detector_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [tpd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [tpd_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                            bin_valid,
	output logic                                 bin_stall,
	input  wire logic [15:0]                     amplitude,
	input  wire logic                            last,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output logic                                 treble_found,
	output logic [tpd_pkg::BIN_W-1:0]            peak_bin,
	output logic [tpd_pkg::FREQ_W-1:0]           frequency_q8
);
	import tpd_pkg::*;

	cfg_t              cfg_q;
	logic              push, pop, empty;
	frame_t            push_frame, head;
	logic [QCNT_W-1:0] queue_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bin_count      <= BC_W'(8192);
			cfg_q.low_bin        <= BIN_W'(7);
			cfg_q.peak_start_bin <= BIN_W'(372);
			cfg_q.high_bin       <= BIN_W'(1672);
			cfg_q.threshold_q16  <= THR_W'(5898);
			cfg_q.hz_per_bin_q16 <= HZ_W'(176400);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BIN_COUNT:  cfg_q.bin_count      <= cfg_data[BC_W-1:0];
				CFG_LOW_BIN:    cfg_q.low_bin        <= cfg_data[BIN_W-1:0];
				CFG_PEAK_START: cfg_q.peak_start_bin <= cfg_data[BIN_W-1:0];
				CFG_HIGH_BIN:   cfg_q.high_bin       <= cfg_data[BIN_W-1:0];
				CFG_THRESHOLD:  cfg_q.threshold_q16  <= cfg_data[THR_W-1:0];
				CFG_HZ_PER_BIN: cfg_q.hz_per_bin_q16 <= cfg_data[HZ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tpd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.bin_valid   (bin_valid),
		.bin_stall   (bin_stall),
		.amplitude   (amplitude),
		.last        (last),
		.queue_count (queue_count),
		.push        (push),
		.push_frame  (push_frame)
	);

	tpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.count      (queue_count)
	);

	tpd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.treble_found (treble_found),
		.peak_bin     (peak_bin),
		.frequency_q8 (frequency_q8)
	);

endmodule

`default_nettype wire

### bench/treble_peak_detector_unit_test.sv
`timescale 1ns / 1ps

module treble_peak_detector_unit_test;
	import tpd_pkg::*;

	localparam int DRAIN_CYCLES = 32;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_BINS  = 700;

	typedef struct packed {
		logic              found;
		logic [BIN_W-1:0]  pbin;
		logic [FREQ_W-1:0] freq;
	} treble_result_t;

	typedef enum logic [1:0] {ROW_WRITE, ROW_BIN, ROW_BIN_TYPED} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		logic [15:0]          amp;
		logic                 lst;
		treble_result_t       want;
	} step_row_t;

	localparam step_row_t SCRIPT [33] = '{
		'{ROW_BIN_TYPED, CFG_BIN_COUNT,  24'd0,        16'hFFFF, 1'b1, '{1'b0, 14'd0, 26'd0}},
		'{ROW_WRITE,     CFG_BIN_COUNT,  24'd16,       16'd0,    1'b0, '0},
		'{ROW_WRITE,     CFG_LOW_BIN,    24'd0,        16'd0,    1'b0, '0},
		'{ROW_WRITE,     CFG_PEAK_START, 24'd0,        16'd0,    1'b0, '0},
		'{ROW_WRITE,     CFG_HIGH_BIN,   24'd3,        16'd0,    1'b0, '0},
		'{ROW_WRITE,     CFG_THRESHOLD,  24'd0,        16'd0,    1'b0, '0},
		'{ROW_WRITE,     CFG_HZ_PER_BIN, 24'd0,        16'd0,    1'b0, '0},
		'{ROW_BIN,       CFG_BIN_COUNT,  24'd0,        16'd0,    1'b0, '0},
		'{ROW_BIN_TYPED, CFG_BIN_COUNT,  24'd0,        16'hFFFF, 1'b1, '{1'b1, 14'd1, 26'd0}},
		// high bin outside the frame
		'{ROW_WRITE,     CFG_HIGH_BIN,   24'd16,       16'd0,    1'b0, '0},
		'{ROW_BIN,       CFG_BIN_COUNT,  24'd0,        16'd5,    1'b0, '0},
		'{ROW_BIN_TYPED, CFG_BIN_COUNT,  24'd0,        16'd7,    1'b1, '{1'b0, 14'd1, 26'd0}},
		// low above high: empty first moment
		'{ROW_WRITE,     CFG_HIGH_BIN,   24'd3,        16'd0,    1'b0, '0},
		'{ROW_WRITE,     CFG_LOW_BIN,    24'd5,        16'd0,    1'b0, '0},
		'{ROW_BIN,       CFG_BIN_COUNT,  24'd0,        16'd9,    1'b0, '0},
		'{ROW_BIN_TYPED, CFG_BIN_COUNT,  24'd0,        16'd3,    1'b1, '{1'b0, 14'd0, 26'd0}},
		// nothing in the peak range
		'{ROW_WRITE,     CFG_LOW_BIN,    24'd0,        16'd0,    1'b0, '0},
		'{ROW_WRITE,     CFG_PEAK_START, 24'd2,        16'd0,    1'b0, '0},
		'{ROW_BIN,       CFG_BIN_COUNT,  24'd0,        16'd0,    1'b0, '0},
		'{ROW_BIN_TYPED, CFG_BIN_COUNT,  24'd0,        16'd4,    1'b1, '{1'b1, 14'd0, 26'd0}},
		// max threshold, ties in the peak search
		'{ROW_WRITE,     CFG_BIN_COUNT,  24'd16384,    16'd0,    1'b0, '0},
		'{ROW_WRITE,     CFG_PEAK_START, 24'd0,        16'd0,    1'b0, '0},
		'{ROW_WRITE,     CFG_THRESHOLD,  24'd65535,    16'd0,    1'b0, '0},
		'{ROW_WRITE,     CFG_HZ_PER_BIN, 24'hFFFFFF,   16'd0,    1'b0, '0},
		'{ROW_BIN,       CFG_BIN_COUNT,  24'd0,        16'hFFFF, 1'b0, '0},
		'{ROW_BIN,       CFG_BIN_COUNT,  24'd0,        16'hFFFF, 1'b0, '0},
		'{ROW_BIN,       CFG_BIN_COUNT,  24'd0,        16'd0,    1'b0, '0},
		'{ROW_BIN_TYPED, CFG_BIN_COUNT,  24'd0,        16'd0,    1'b1, '{1'b0, 14'd0, 26'd0}},
		'{ROW_WRITE,     CFG_THRESHOLD,  24'd0,        16'd0,    1'b0, '0},
		'{ROW_BIN,       CFG_BIN_COUNT,  24'd0,        16'd1,    1'b0, '0},
		'{ROW_BIN,       CFG_BIN_COUNT,  24'd0,        16'h8000, 1'b0, '0},
		'{ROW_BIN,       CFG_BIN_COUNT,  24'd0,        16'hFFFF, 1'b0, '0},
		'{ROW_BIN,       CFG_BIN_COUNT,  24'd0,        16'd0,    1'b1, '0}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 bin_valid;
	logic                 bin_stall;
	logic [15:0]          amplitude;
	logic                 last;
	logic                 result_valid;
	logic                 result_stall;
	logic                 treble_found;
	logic [BIN_W-1:0]     peak_bin;
	logic [FREQ_W-1:0]    frequency_q8;

	treble_peak_detector_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.bin_valid    (bin_valid),
		.bin_stall    (bin_stall),
		.amplitude    (amplitude),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.treble_found (treble_found),
		.peak_bin     (peak_bin),
		.frequency_q8 (frequency_q8)
	);

	// detector state as seen from the bin stream
	cfg_t             active_cfg;
	logic [BIN_W-1:0] bin_pos;
	logic [M1_W-1:0]  m1_acc;
	logic [M2_W-1:0]  m2_acc;
	logic [15:0]      peak_amp;
	logic [BIN_W-1:0] peak_pos;

	treble_result_t frame_results [$];
	int unsigned    mismatches = 0;
	int unsigned    bins_sent = 0;
	bit             steady = 1'b0;
	bit             hold_off_req = 1'b0;

	function automatic bit fold_bin(input logic [15:0] amp, input logic lst,
			output treble_result_t res);
		logic [63:0]  q;
		logic [127:0] lhs;
		logic [127:0] rhs;
		logic [63:0]  freq_full;
		q = 64'(bin_pos);
		res = '0;
		if (bin_pos >= active_cfg.low_bin && bin_pos <= active_cfg.high_bin) begin
			m1_acc = m1_acc + M1_W'(64'(amp) * q);
			m2_acc = m2_acc + M2_W'(64'(amp) * q * q);
		end
		if (bin_pos >= active_cfg.peak_start_bin && bin_pos < active_cfg.high_bin
				&& amp > peak_amp) begin
			peak_amp = amp;
			peak_pos = bin_pos;
		end
		// 14-bit index wraps at MAX_BINS
		bin_pos = bin_pos + 1'b1;
		if (!lst)
			return 1'b0;
		lhs = 128'(m2_acc) << 16;
		rhs = 128'(m1_acc) * 128'(active_cfg.threshold_q16) * 128'(active_cfg.bin_count);
		res.found = (active_cfg.high_bin < active_cfg.bin_count) && (m1_acc != '0)
			&& (lhs > rhs);
		if (peak_amp != '0)
			res.pbin = peak_pos;
		if (res.found && peak_amp != '0) begin
			freq_full = (64'(peak_pos) * 64'(active_cfg.hz_per_bin_q16) + 64'd128) >> 8;
			if (freq_full > 64'({FREQ_W{1'b1}}))
				res.freq = '1;
			else
				res.freq = freq_full[FREQ_W-1:0];
		end
		bin_pos = '0;
		m1_acc = '0;
		m2_acc = '0;
		peak_amp = '0;
		peak_pos = '0;
		return 1'b1;
	endfunction

	function automatic logic [15:0] rand_amp();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 3));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic offer_bin(input logic [15:0] amp, input logic lst,
			input bit typed = 1'b0, input treble_result_t want = '0);
		treble_result_t got;
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 31) begin
			bin_valid <= 1'b0;
			@(negedge clk);
		end
		bin_valid <= 1'b1;
		amplitude <= amp;
		last <= lst;
		@(posedge clk);
		while (bin_stall)
			@(posedge clk);
		bins_sent++;
		if (fold_bin(amp, lst, got))
			frame_results.push_back(typed ? want : got);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		bin_valid <= 1'b0;
		while (frame_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_BIN_COUNT:  active_cfg.bin_count = val[BC_W-1:0];
			CFG_LOW_BIN:    active_cfg.low_bin = val[BIN_W-1:0];
			CFG_PEAK_START: active_cfg.peak_start_bin = val[BIN_W-1:0];
			CFG_HIGH_BIN:   active_cfg.high_bin = val[BIN_W-1:0];
			CFG_THRESHOLD:  active_cfg.threshold_q16 = val[THR_W-1:0];
			CFG_HZ_PER_BIN: active_cfg.hz_per_bin_q16 = val[HZ_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_all(input cfg_t s);
		write_reg(CFG_BIN_COUNT, CFG_W'(s.bin_count));
		write_reg(CFG_LOW_BIN, CFG_W'(s.low_bin));
		write_reg(CFG_PEAK_START, CFG_W'(s.peak_start_bin));
		write_reg(CFG_HIGH_BIN, CFG_W'(s.high_bin));
		write_reg(CFG_THRESHOLD, CFG_W'(s.threshold_q16));
		write_reg(CFG_HZ_PER_BIN, CFG_W'(s.hz_per_bin_q16));
	endtask

	// random settings, then a few frames sized around the moment range
	task automatic random_phase(input bit calm);
		cfg_t        s;
		int unsigned span;
		int unsigned bc;
		int unsigned len;
		wait_drained();
		steady = calm;
		span = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
		case ($urandom_range(0, 9))
			0: s.high_bin = '0;
			1: s.high_bin = '1;
			default: s.high_bin = BIN_W'($urandom_range(0, span));
		endcase
		case ($urandom_range(0, 7))
			0: s.low_bin = '0;
			1: s.low_bin = '1;
			default: s.low_bin = BIN_W'($urandom_range(0, s.high_bin));
		endcase
		case ($urandom_range(0, 7))
			0: s.peak_start_bin = '0;
			1: s.peak_start_bin = '1;
			default: s.peak_start_bin = BIN_W'($urandom_range(0, s.high_bin));
		endcase
		bc = s.high_bin + $urandom_range(1, 64);
		if (bc > MAX_BINS)
			bc = MAX_BINS;
		case ($urandom_range(0, 9))
			0: s.bin_count = BC_W'(1);
			1: s.bin_count = BC_W'(MAX_BINS);
			2: s.bin_count = BC_W'($urandom_range(1, s.high_bin + 1));
			default: s.bin_count = BC_W'(bc);
		endcase
		case ($urandom_range(0, 7))
			0: s.threshold_q16 = '0;
			1: s.threshold_q16 = '1;
			default: s.threshold_q16 = THR_W'($urandom_range(0, 65535));
		endcase
		case ($urandom_range(0, 7))
			0: s.hz_per_bin_q16 = '0;
			1: s.hz_per_bin_q16 = '1;
			default: s.hz_per_bin_q16 = HZ_W'($urandom);
		endcase
		program_all(s);
		repeat ($urandom_range(2, 8)) begin
			if ($urandom_range(0, 3) == 0 && s.high_bin < 64)
				len = s.high_bin + 1;
			else
				len = $urandom_range(1, span);
			for (int i = 0; i < len; i++)
				offer_bin(rand_amp(), i == len - 1);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				result_stall <= !steady && ($urandom_range(0, 99) < 31);
			end
		end
	end

	always @(posedge clk) begin : result_check
		treble_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (frame_results.size() == 0) begin
				$error("result with none pending: treble_found %0d peak_bin %0d frequency_q8 %0d",
					treble_found, peak_bin, frequency_q8);
				mismatches++;
			end else begin
				want = frame_results.pop_front();
				if (treble_found !== want.found) begin
					$error("treble_found: expected %0d, got %0d", want.found, treble_found);
					mismatches++;
				end
				if (peak_bin !== want.pbin) begin
					$error("peak_bin: expected %0d, got %0d", want.pbin, peak_bin);
					mismatches++;
				end
				if (frequency_q8 !== want.freq) begin
					$error("frequency_q8: expected %0d, got %0d", want.freq, frequency_q8);
					mismatches++;
				end
			end
		end
	end

	initial begin
		cfg_t        s;
		int unsigned start_count;
		int unsigned phase;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_BIN_COUNT;
		cfg_data = '0;
		bin_valid = 1'b0;
		amplitude = '0;
		last = 1'b0;
		active_cfg = '{bin_count: BC_W'(8192), low_bin: BIN_W'(7), peak_start_bin: BIN_W'(372),
			high_bin: BIN_W'(1672), threshold_q16: THR_W'(5898), hz_per_bin_q16: HZ_W'(176400)};
		bin_pos = '0;
		m1_acc = '0;
		m2_acc = '0;
		peak_amp = '0;
		peak_pos = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		foreach (SCRIPT[i]) begin
			if (SCRIPT[i].kind == ROW_WRITE) begin
				wait_drained();
				write_reg(SCRIPT[i].idx, SCRIPT[i].data);
			end else begin
				offer_bin(SCRIPT[i].amp, SCRIPT[i].lst, SCRIPT[i].kind == ROW_BIN_TYPED,
					SCRIPT[i].want);
			end
		end

		phase = 0;
		start_count = bins_sent;
		while (bins_sent - start_count < RANDOM_BINS || phase <= 10) begin
			random_phase(phase >= 4 && phase < 9);
			if (phase == 10) begin
				// short frames while results are held back: fills the frame queue
				wait_drained();
				steady = 1'b0;
				s = '{bin_count: BC_W'(8), low_bin: '0, peak_start_bin: '0, high_bin: BIN_W'(3),
					threshold_q16: THR_W'($urandom_range(0, 65535)), hz_per_bin_q16: HZ_W'($urandom)};
				program_all(s);
				hold_off_req = 1'b1;
				repeat (48) begin
					offer_bin(rand_amp(), 1'b0);
					offer_bin(rand_amp(), 1'b1);
				end
			end
			phase++;
		end

		// peak high enough to saturate the frequency
		wait_drained();
		steady = 1'b0;
		s = '{bin_count: BC_W'(MAX_BINS), low_bin: '0, peak_start_bin: BIN_W'(1000),
			high_bin: BIN_W'(1100), threshold_q16: '0, hz_per_bin_q16: '1};
		program_all(s);
		for (int i = 0; i <= 1100; i++)
			offer_bin((i == 1050) ? 16'hFFFF : 16'($urandom_range(0, 60000)), i == 1100);

		wait_drained();
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
